/* rtl/core/lrcd_pkg.sv */
package lrcd_pkg;

  localparam int BUF_AW      = 16;
  localparam int BUF_DEPTH   = 1 << BUF_AW;
  localparam int CHUNK_BYTES = 16;
  localparam int LANE_W      = $clog2(CHUNK_BYTES);
  localparam int CNT_W       = 11;

  localparam logic [7:0] END_MARK   = 8'hFF;
  localparam logic [2:0] EXT_PREFIX = 3'b111;
  localparam logic [9:0] EXT_CNT_MASK = 10'h3FF;

  // decode phases
  localparam logic [2:0] PH_CMD    = 3'd0;
  localparam logic [2:0] PH_CNT_LO = 3'd1;
  localparam logic [2:0] PH_CNT_HI = 3'd2;
  localparam logic [2:0] PH_OP1    = 3'd3;
  localparam logic [2:0] PH_OP2    = 3'd4;
  localparam logic [2:0] PH_RAW    = 3'd5;
  localparam logic [2:0] PH_START  = 3'd6;

  // command modes
  localparam logic [2:0] MODE_RAW     = 3'd0;
  localparam logic [2:0] MODE_FILL    = 3'd1;
  localparam logic [2:0] MODE_ALT     = 3'd2;
  localparam logic [2:0] MODE_INC     = 3'd3;
  localparam logic [2:0] MODE_ABS     = 3'd4;
  localparam logic [2:0] MODE_ABS_INV = 3'd5;
  localparam logic [2:0] MODE_REL     = 3'd6;
  localparam logic [2:0] MODE_SKIP    = 3'd7;

  // run kinds
  localparam logic [2:0] K_FILL = 3'd0;
  localparam logic [2:0] K_ALT  = 3'd1;
  localparam logic [2:0] K_INC  = 3'd2;
  localparam logic [2:0] K_COPY = 3'd3;
  localparam logic [2:0] K_END  = 3'd4;

  typedef struct packed {
    logic        valid;
    logic        tail;
    logic        is_end;
    logic [7:0]  data;
    logic [15:0] addr;
    logic [15:0] total;
  } push_t;

endpackage

/* rtl/core/lrcd_buf.sv */
module lrcd_buf
  import lrcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [BUF_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  output logic              clearing
);

  logic [7:0]        mem [BUF_DEPTH];
  logic [BUF_AW-1:0] clr_addr;

  // zero pass over the whole buffer after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {BUF_AW{1'b1}}) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/lrcd_pack.sv */
module lrcd_pack
  import lrcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] write_address,
  output logic [63:0] bytes_low,
  output logic [63:0] bytes_high,
  output logic [4:0]  byte_count,
  output logic        last,
  output logic        end_of_data,
  output logic [15:0] total_size
);

  logic [7:0]        lanes [CHUNK_BYTES];
  logic [7:0]        lane_v [CHUNK_BYTES];
  logic [LANE_W-1:0] k;
  logic [15:0]       caddr;
  logic              emit;

  always_comb begin
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      if (push.is_end) lane_v[i] = 8'h00;
      else if (LANE_W'(i) == k) lane_v[i] = push.data;
      else if (LANE_W'(i) < k) lane_v[i] = lanes[i];
      else lane_v[i] = 8'h00;
    end
    emit = push.valid && (push.is_end || push.tail || k == {LANE_W{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (push.valid) begin
        if (emit) begin
          out_valid <= 1'b1;
          k         <= '0;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      if (emit) begin
        write_address <= (k == '0 || push.is_end) ? push.addr : caddr;
        for (int i = 0; i < 8; i++) begin
          bytes_low[8*i +: 8]  <= lane_v[i];
          bytes_high[8*i +: 8] <= lane_v[i+8];
        end
        byte_count  <= push.is_end ? 5'd0 : 5'({1'b0, k} + 5'd1);
        // only the chunk that closes the run is marked
        last        <= push.tail;
        end_of_data <= push.is_end;
        total_size  <= push.is_end ? push.total : 16'h0000;
      end else begin
        lanes[k] <= push.data;
        if (k == '0) caddr <= push.addr;
      end
    end
  end

endmodule

/* rtl/core/lz_rle_command_decompressor_core.sv */
// Decodes an LZ/RLE command stream one byte per accepted word into a 64 KiB
// buffer and reports every written byte in chunks of up to 16 bytes; byte
// 0xFF in command position ends the stream with a result carrying the total
// size. A raw data byte is written as a run of one byte. A fill or copy run
// holds off input after its last operand; in a copy run each byte is read
// from the single-port-read buffer and written back before the next read.
// A run stalls while the output register is still held by the sink, and
// input waits until the run is done. After reset the buffer is zeroed in a
// pass with input held off; configuration writes are taken during that pass.
module lz_rle_command_decompressor_core
  import lrcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] write_address,
  output logic [63:0] bytes_low,
  output logic [63:0] bytes_high,
  output logic [4:0]  byte_count,
  output logic        last,
  output logic        end_of_data,
  output logic [15:0] total_size
);

  logic [15:0]      start_reg;
  logic [15:0]      wp;
  logic [2:0]       phase;
  logic [2:0]       mode;
  logic             inv_flag;
  logic [7:0]       held;
  logic [CNT_W-1:0] rem;

  logic             run_active;
  logic [2:0]       kind;
  logic [CNT_W-1:0] left;
  logic [7:0]       val0;
  logic [7:0]       val1;
  logic [15:0]      src;
  logic             run_inv;
  logic             rd_pend;

  logic             clearing;
  logic             acc;
  logic             slot_free;
  logic [15:0]      wp_cur;
  logic [2:0]       ph_eff;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic [2:0]       next_ph;
  logic [CNT_W-1:0] cnt_ext;
  push_t            push;

  always_comb begin
    in_ready  = !clearing && !run_active;
    acc       = in_valid && in_ready;
    slot_free = !out_valid || out_ready;
    wp_cur    = (phase == PH_START) ? start_reg : wp;
    ph_eff    = (phase == PH_START || phase == 3'd7) ? PH_CMD : phase;
    cnt_ext   = CNT_W'({stream_byte, held} & {6'd0, EXT_CNT_MASK}) + 1'b1;
    rd_en     = run_active && kind == K_COPY && !rd_pend;

    // phase after the count is known
    case (mode)
      MODE_SKIP: next_ph = PH_CMD;
      MODE_RAW:  next_ph = PH_RAW;
      default:   next_ph = PH_OP1;
    endcase

    push        = '0;
    push.addr   = wp;
    push.total  = wp - start_reg;
    push.tail   = (left == CNT_W'(1)) || kind == K_END;
    push.is_end = kind == K_END;
    if (run_active && slot_free) begin
      case (kind)
        K_FILL, K_ALT, K_INC: begin
          push.valid = 1'b1;
          push.data  = val0;
        end
        K_COPY: begin
          push.valid = rd_pend;
          push.data  = rd_data ^ {8{run_inv}};
        end
        K_END: push.valid = 1'b1;
        default: push.valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg  <= 16'h0000;
      phase      <= PH_START;
      mode       <= MODE_RAW;
      inv_flag   <= 1'b0;
      rem        <= '0;
      run_active <= 1'b0;
      rd_pend    <= 1'b0;
      kind       <= K_FILL;
      left       <= '0;
    end else begin
      if (cfg_wr_en) start_reg <= cfg_wr_data;

      if (rd_en) begin
        rd_pend <= 1'b1;
        src     <= src + 1'b1;
      end

      if (push.valid) begin
        if (push.is_end) begin
          wp         <= start_reg;
          run_active <= 1'b0;
        end else begin
          wp      <= wp + 1'b1;
          left    <= left - 1'b1;
          rd_pend <= 1'b0;
          if (left == CNT_W'(1)) run_active <= 1'b0;
          case (kind)
            K_ALT: begin
              val0 <= val1;
              val1 <= val0;
            end
            K_INC:   val0 <= val0 + 1'b1;
            default: val0 <= val0;
          endcase
        end
      end

      if (acc) begin
        wp <= wp_cur;
        case (ph_eff)
          PH_CNT_LO: begin
            held  <= stream_byte;
            phase <= PH_CNT_HI;
          end
          PH_CNT_HI: begin
            rem   <= cnt_ext;
            phase <= next_ph;
          end
          PH_OP1: begin
            left <= rem;
            val0 <= stream_byte;
            src  <= wp - {8'h00, stream_byte};
            if (mode == MODE_FILL || mode == MODE_INC || mode == MODE_REL) begin
              run_active <= 1'b1;
              phase      <= PH_CMD;
              run_inv    <= inv_flag;
              kind       <= (mode == MODE_FILL) ? K_FILL :
                            (mode == MODE_INC) ? K_INC : K_COPY;
            end else begin
              held  <= stream_byte;
              phase <= PH_OP2;
            end
          end
          PH_OP2: begin
            run_active <= 1'b1;
            left       <= rem;
            phase      <= PH_CMD;
            val0       <= held;
            val1       <= stream_byte;
            src        <= {stream_byte, held};
            run_inv    <= mode == MODE_ABS_INV;
            kind       <= (mode == MODE_ALT) ? K_ALT : K_COPY;
          end
          PH_RAW: begin
            run_active <= 1'b1;
            kind       <= K_FILL;
            left       <= CNT_W'(1);
            val0       <= stream_byte;
            rem        <= rem - 1'b1;
            if (rem <= CNT_W'(1)) phase <= PH_CMD;
          end
          default: begin
            if (stream_byte == END_MARK) begin
              run_active <= 1'b1;
              kind       <= K_END;
              phase      <= PH_START;
            end else begin
              inv_flag <= stream_byte[5];
              if (stream_byte[7:5] == EXT_PREFIX) begin
                mode  <= stream_byte[4:2];
                phase <= PH_CNT_LO;
              end else begin
                mode <= stream_byte[7:5];
                rem  <= CNT_W'(stream_byte[4:0]) + 1'b1;
                case (stream_byte[7:5])
                  MODE_RAW: phase <= PH_RAW;
                  default:  phase <= PH_OP1;
                endcase
              end
            end
          end
        endcase
      end
    end
  end

  lrcd_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (src[BUF_AW-1:0]),
    .rd_data  (rd_data),
    .wr_en    (push.valid && !push.is_end),
    .wr_addr  (wp[BUF_AW-1:0]),
    .wr_data  (push.data),
    .clearing (clearing)
  );

  lrcd_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .write_address (write_address),
    .bytes_low     (bytes_low),
    .bytes_high    (bytes_high),
    .byte_count    (byte_count),
    .last          (last),
    .end_of_data   (end_of_data),
    .total_size    (total_size)
  );

endmodule
